### hw/rtl/ubsd_pkg.sv
// Package for the UTF-8 BMP stream decoder: payload types, queue entry type,
// byte classification constants and helper functions. No dependencies.
`default_nettype none

package ubsd_pkg;

  typedef logic [7:0]  text_byte_t;
  typedef logic [15:0] code_point_t;

  localparam code_point_t REPL_RESET = 16'hFFFD;

  // Byte classification constants
  localparam text_byte_t CONT_MASK  = 8'hC0;
  localparam text_byte_t CONT_TAG   = 8'h80;
  localparam text_byte_t LEAD2_LO   = 8'hC2;
  localparam text_byte_t LEAD3_HI   = 8'hEF;
  localparam text_byte_t LEAD3_MASK = 8'hF0;
  localparam text_byte_t LEAD3_TAG  = 8'hE0;
  localparam text_byte_t ASCII_LIM  = 8'h80;
  localparam code_point_t MIN_2BYTE = 16'h0080;
  localparam code_point_t MIN_3BYTE = 16'h0800;

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef logic [QPTR_W-1:0] qptr_t;
  typedef logic [QPTR_W:0]   qcount_t;

  // One request: cnt results (1..3); all but the last are the replacement
  // code; the last is val when has_val is set, else the replacement code.
  typedef struct packed {
    logic [1:0]  cnt;
    logic        has_val;
    code_point_t val;
  } queue_entry_t;

  // Outcome of decoding a byte with nothing held
  typedef struct packed {
    logic emit;
    logic is_val;
    logic hold;
  } start_t;

  function automatic logic is_cont(text_byte_t b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

  function automatic start_t start_decode(text_byte_t b);
    start_t s;
    s = '0;
    if (b < ASCII_LIM) begin
      s.emit   = 1'b1;
      s.is_val = 1'b1;
    end else if (b >= LEAD2_LO && b <= LEAD3_HI) begin
      s.hold = 1'b1;
    end else begin
      s.emit = 1'b1;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ubsd_if.sv
// Valid/ready channel interfaces for the decoder: byte input and code point
// output. Depends on ubsd_pkg for the payload types.
`default_nettype none

interface ubsd_byte_if;
  import ubsd_pkg::*;
  logic       valid;
  logic       ready;
  text_byte_t text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface ubsd_cp_if;
  import ubsd_pkg::*;
  logic        valid;
  logic        ready;
  code_point_t code_point;
  logic        last_of_run;

  modport source (output valid, output code_point, output last_of_run, input ready);
  modport sink   (input valid, input code_point, input last_of_run, output ready);
endinterface

`default_nettype wire

### hw/rtl/utf8_bmp_stream_decoder.sv
// Top level of the UTF-8 BMP stream decoder: replacement code register and
// the front, queue and back parts. Depends on ubsd_pkg, ubsd_if and submodules.
`default_nettype none

// Takes one UTF-8 byte per cycle on in_byte_i and gives 16-bit code points on
// out_cp_o, with last_of_run set on the final code point that a byte causes.
// A byte enters in the cycle it is offered as long as the four-entry request
// queue has room; each byte causes zero to three code points, and the output
// register issues one code point per cycle, so bytes flow at one per cycle
// while they average at most one result each and the sink keeps up. Broken
// or overlong sequences, bad lead bytes and stray continuation bytes yield the
// replacement code held in the cfg register (reset FFFD), one per offending
// byte; a zero byte flushes the held bytes as replacements. Write the
// replacement code only while the decoder is idle.
module utf8_bmp_stream_decoder (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire ubsd_pkg::code_point_t cfg_wdata_i,
  ubsd_byte_if.sink                  in_byte_i,
  ubsd_cp_if.source                  out_cp_o
);
  import ubsd_pkg::*;

  code_point_t  repl_q, repl_d;
  logic         push;
  logic         full;
  logic         pop;
  logic         empty;
  queue_entry_t push_entry;
  queue_entry_t head_entry;

  assign repl_d = cfg_we_i ? cfg_wdata_i : repl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= REPL_RESET;
    end else begin
      repl_q <= repl_d;
    end
  end

  ubsd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (in_byte_i),
    .q_full_i (full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  ubsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty)
  );

  ubsd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .repl_i  (repl_q),
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .cp_o    (out_cp_o)
  );

endmodule

`default_nettype wire

### hw/rtl/ubsd_front.sv
// Front part: accepts text bytes, tracks the held sequence and turns each
// byte into at most one queue request. Depends on ubsd_pkg and ubsd_if.
`default_nettype none

module ubsd_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ubsd_byte_if.sink                  byte_i,
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output ubsd_pkg::queue_entry_t     entry_o
);
  import ubsd_pkg::*;

  text_byte_t lead_q, lead_d;
  text_byte_t second_q, second_d;
  logic [1:0] count_q, count_d;

  text_byte_t  b;
  start_t      s;
  logic        use_start;
  logic [1:0]  pre;
  logic [1:0]  n;
  logic        has_val;
  code_point_t val;
  code_point_t v2;
  code_point_t v3;
  logic        accept;

  assign b      = byte_i.text_byte;
  assign s      = start_decode(b);
  assign v2     = {5'b0, lead_q[4:0], b[5:0]};
  assign v3     = {lead_q[3:0], second_q[5:0], b[5:0]};
  assign accept = byte_i.valid && byte_i.ready;

  always_comb begin
    n         = 2'd0;
    has_val   = 1'b0;
    val       = {8'h00, b};
    pre       = 2'd0;
    use_start = 1'b0;
    lead_d    = '0;
    second_d  = '0;
    count_d   = 2'd0;
    if (b == '0) begin
      // end of text: flush each held byte as a replacement
      n = (count_q == 2'd0) ? 2'd0 : ((count_q == 2'd1) ? 2'd1 : 2'd2);
    end else if (count_q == 2'd0) begin
      use_start = 1'b1;
    end else if (count_q == 2'd1) begin
      if ((lead_q & LEAD3_MASK) == LEAD3_TAG) begin
        if (is_cont(b)) begin
          lead_d   = lead_q;
          second_d = b;
          count_d  = 2'd2;
        end else begin
          pre       = 2'd1;
          use_start = 1'b1;
        end
      end else if (is_cont(b)) begin
        if (v2 >= MIN_2BYTE) begin
          n       = 2'd1;
          has_val = 1'b1;
          val     = v2;
        end else begin
          n = 2'd2;
        end
      end else begin
        pre       = 2'd1;
        use_start = 1'b1;
      end
    end else begin
      if (is_cont(b) && v3 >= MIN_3BYTE) begin
        n       = 2'd1;
        has_val = 1'b1;
        val     = v3;
      end else begin
        pre       = 2'd2;
        use_start = 1'b1;
      end
    end

    // broken or empty state: decode the current byte afresh
    if (use_start) begin
      n       = pre + {1'b0, s.emit};
      has_val = s.emit && s.is_val;
      if (s.hold) begin
        lead_d  = b;
        count_d = 2'd1;
      end
    end
  end

  assign byte_i.ready    = !q_full_i;
  assign push_o          = accept && (n != 2'd0);
  assign entry_o.cnt     = n;
  assign entry_o.has_val = has_val;
  assign entry_o.val     = val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q   <= '0;
      second_q <= '0;
      count_q  <= 2'd0;
    end else if (accept) begin
      lead_q   <= lead_d;
      second_q <= second_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ubsd_queue.sv
// Short request queue between the front and back parts of the decoder.
// Depends on ubsd_pkg.
`default_nettype none

module ubsd_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire ubsd_pkg::queue_entry_t entry_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output ubsd_pkg::queue_entry_t     entry_o,
  output logic                       empty_o
);
  import ubsd_pkg::*;

  queue_entry_t slots_q [QDEPTH];
  qptr_t        wr_q, wr_d;
  qptr_t        rd_q, rd_d;
  qcount_t      cnt_q, cnt_d;
  logic         do_push;
  logic         do_pop;

  assign full_o  = (cnt_q == qcount_t'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slots_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + qptr_t'(1) : wr_q;
    rd_d  = do_pop ? rd_q + qptr_t'(1) : rd_q;
    cnt_d = cnt_q + qcount_t'(do_push) - qcount_t'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ubsd_back.sv
// Back part: expands each queued request into the output register, one code
// point per cycle while the sink keeps up. Depends on ubsd_pkg and ubsd_if.
`default_nettype none

module ubsd_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ubsd_pkg::code_point_t repl_i,
  input  wire ubsd_pkg::queue_entry_t entry_i,
  input  wire logic                  empty_i,
  output logic                       pop_o,
  ubsd_cp_if.source                  cp_o
);
  import ubsd_pkg::*;

  logic        valid_q, valid_d;
  code_point_t cp_q, cp_d;
  logic        last_q, last_d;
  logic [1:0]  idx_q, idx_d;
  logic        load;
  logic        final_one;

  assign load      = !valid_q || cp_o.ready;
  assign final_one = (idx_q == entry_i.cnt - 2'd1);
  assign pop_o     = load && !empty_i && final_one;

  always_comb begin
    valid_d = valid_q;
    cp_d    = cp_q;
    last_d  = last_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        cp_d   = (final_one && entry_i.has_val) ? entry_i.val : repl_i;
        last_d = final_one;
        // advance within the request, or drop it once its last result is out
        idx_d  = final_one ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q   <= cp_d;
    last_q <= last_d;
  end

  assign cp_o.valid       = valid_q;
  assign cp_o.code_point  = cp_q;
  assign cp_o.last_of_run = last_q;

endmodule

`default_nettype wire
